/* hw/rtl/lav_pkg.sv */
`default_nettype none
// lav_pkg: shared types and fixed-point constants for the look-at view matrix unit.
// No dependencies.
package lav_pkg;

  localparam int COORD_W   = 32;
  localparam int UNIT_W    = 32;
  localparam int FRAC_BITS = 30;
  localparam int MAG_W     = 31;

  localparam int SQ_STEPS  = 2;
  localparam int SQ_STAGES = 16;
  localparam int DV_STEPS  = 2;
  localparam int DV_STAGES = 16;

  localparam logic signed [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1) << FRAC_BITS;

  typedef logic [2:0][COORD_W-1:0] cvec_t;
  typedef logic [2:0][UNIT_W-1:0]  uvec_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] eye_x;
    logic signed [COORD_W-1:0] eye_y;
    logic signed [COORD_W-1:0] eye_z;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
    logic signed [COORD_W-1:0] up_x;
    logic signed [COORD_W-1:0] up_y;
    logic signed [COORD_W-1:0] up_z;
  } in_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0]  side_x;
    logic signed [UNIT_W-1:0]  side_y;
    logic signed [UNIT_W-1:0]  side_z;
    logic signed [UNIT_W-1:0]  upper_x;
    logic signed [UNIT_W-1:0]  upper_y;
    logic signed [UNIT_W-1:0]  upper_z;
    logic signed [UNIT_W-1:0]  back_x;
    logic signed [UNIT_W-1:0]  back_y;
    logic signed [UNIT_W-1:0]  back_z;
    logic signed [COORD_W-1:0] shift_x;
    logic signed [COORD_W-1:0] shift_y;
    logic signed [COORD_W-1:0] shift_z;
  } out_t;

endpackage
`default_nettype wire

/* hw/rtl/look_at_view_matrix_unit.sv */
`default_nettype none
// look_at_view_matrix_unit: right-handed look-at view matrix, fixed-point pipeline.
// Depends on lav_pkg, lav_scale, lav_norm and lav_xlat.
//
// Takes one camera setup (eye, target, up in signed Q16.16) per cycle, unless the
// output stalls, and returns the rows side, upper, back in Q2.30 and the saturated
// Q16.16 translations, one result per cycle. Each of the two normalisers in series
// holds a 16-stage square root and a 16-stage three-lane divider resolving two bits
// per stage. A stalled result freezes the whole pipeline in place; item_stall is
// high exactly while a result waits and result_stall is high.
module look_at_view_matrix_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  lav_pkg::in_t   item,
  output logic           result_valid,
  input  logic           result_stall,
  output lav_pkg::out_t  result
);
  localparam int COORD_W   = lav_pkg::COORD_W;
  localparam int UNIT_W    = lav_pkg::UNIT_W;
  localparam int MAG_W     = lav_pkg::MAG_W;
  localparam int FRAC_BITS = lav_pkg::FRAC_BITS;
  localparam int D_W       = COORD_W + 1;
  localparam int PROD_W    = 2 * UNIT_W;
  localparam int CX_W      = PROD_W - 1;

  typedef struct packed {
    lav_pkg::cvec_t eye;
    lav_pkg::cvec_t target;
  } pts_t;

  typedef struct packed {
    lav_pkg::cvec_t eye;
    lav_pkg::uvec_t aux;
  } pair_t;

  logic                   adv;
  lav_pkg::cvec_t         up_c;
  pts_t                   pts_c;
  logic                   us_v;
  logic [2:0][MAG_W-1:0]  us_mag;
  logic [2:0]             us_neg;
  pts_t                   us_side;
  logic                   d_v;
  logic [2:0][D_W-1:0]    d_r;
  pair_t                  d_side;
  logic                   f_v;
  lav_pkg::uvec_t         f_unit;
  pair_t                  f_side;
  logic                   x1_v;
  logic signed [PROD_W-1:0] xp [6];
  lav_pkg::uvec_t         x1_f;
  lav_pkg::cvec_t         x1_eye;
  logic                   x2_v;
  logic [2:0][CX_W-1:0]   c_r;
  pair_t                  x2_side;
  logic                   s_v;
  lav_pkg::uvec_t         s_unit;
  pair_t                  s_side;
  logic                   u1_v;
  logic signed [PROD_W-1:0] up_p [6];
  lav_pkg::uvec_t         u1_s, u1_f;
  lav_pkg::cvec_t         u1_eye;
  logic signed [PROD_W-1:0] u_rnd [3];
  logic signed [PROD_W-1:0] u_sh [3];
  lav_pkg::uvec_t         u_c;
  logic                   u2_v;
  lav_pkg::uvec_t         u2_s, u2_u, u2_f;
  lav_pkg::cvec_t         u2_eye;

  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv;

  assign up_c         = {item.up_z, item.up_y, item.up_x};
  assign pts_c.eye    = {item.eye_z, item.eye_y, item.eye_x};
  assign pts_c.target = {item.target_z, item.target_y, item.target_x};

  lav_scale #(
    .IN_W   (COORD_W),
    .SIDE_W ($bits(pts_t))
  ) u_up_scale (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (item_valid),
    .vec       (up_c),
    .in_side   (pts_c),
    .out_valid (us_v),
    .mag       (us_mag),
    .neg       (us_neg),
    .out_side  (us_side)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= D_W'($signed(us_side.eye[i])) - D_W'($signed(us_side.target[i]));
        d_side.aux[i] <= us_neg[i] ? -UNIT_W'(us_mag[i]) : UNIT_W'(us_mag[i]);
      end
      d_side.eye <= us_side.eye;
    end
  end

  lav_norm #(
    .IN_W   (D_W),
    .SIDE_W ($bits(pair_t))
  ) u_norm_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (d_v),
    .vec       (d_r),
    .in_side   (d_side),
    .out_valid (f_v),
    .unit      (f_unit),
    .out_side  (f_side)
  );

  // up hint cross back
  always_ff @(posedge clk) begin
    if (adv) begin
      xp[0]  <= $signed(f_side.aux[1]) * $signed(f_unit[2]);
      xp[1]  <= $signed(f_side.aux[2]) * $signed(f_unit[1]);
      xp[2]  <= $signed(f_side.aux[2]) * $signed(f_unit[0]);
      xp[3]  <= $signed(f_side.aux[0]) * $signed(f_unit[2]);
      xp[4]  <= $signed(f_side.aux[0]) * $signed(f_unit[1]);
      xp[5]  <= $signed(f_side.aux[1]) * $signed(f_unit[0]);
      x1_f   <= f_unit;
      x1_eye <= f_side.eye;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r[0]      <= CX_W'(xp[0] - xp[1]);
      c_r[1]      <= CX_W'(xp[2] - xp[3]);
      c_r[2]      <= CX_W'(xp[4] - xp[5]);
      x2_side.eye <= x1_eye;
      x2_side.aux <= x1_f;
    end
  end

  lav_norm #(
    .IN_W   (CX_W),
    .SIDE_W ($bits(pair_t))
  ) u_norm_side (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (x2_v),
    .vec       (c_r),
    .in_side   (x2_side),
    .out_valid (s_v),
    .unit      (s_unit),
    .out_side  (s_side)
  );

  // back cross side
  always_ff @(posedge clk) begin
    if (adv) begin
      up_p[0] <= $signed(s_side.aux[1]) * $signed(s_unit[2]);
      up_p[1] <= $signed(s_side.aux[2]) * $signed(s_unit[1]);
      up_p[2] <= $signed(s_side.aux[2]) * $signed(s_unit[0]);
      up_p[3] <= $signed(s_side.aux[0]) * $signed(s_unit[2]);
      up_p[4] <= $signed(s_side.aux[0]) * $signed(s_unit[1]);
      up_p[5] <= $signed(s_side.aux[1]) * $signed(s_unit[0]);
      u1_s    <= s_unit;
      u1_f    <= s_side.aux;
      u1_eye  <= s_side.eye;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_rnd[i] = up_p[2*i] - up_p[2*i+1] + (PROD_W'(1) <<< (FRAC_BITS - 1));
      u_sh[i]  = u_rnd[i] >>> FRAC_BITS;
      if (u_sh[i] > PROD_W'(lav_pkg::UNIT_ONE)) begin
        u_c[i] = lav_pkg::UNIT_ONE;
      end else if (u_sh[i] < -PROD_W'(lav_pkg::UNIT_ONE)) begin
        u_c[i] = -lav_pkg::UNIT_ONE;
      end else begin
        u_c[i] = u_sh[i][UNIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u2_s   <= u1_s;
      u2_u   <= u_c;
      u2_f   <= u1_f;
      u2_eye <= u1_eye;
    end
  end

  lav_xlat u_xlat (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (u2_v),
    .side      (u2_s),
    .upper     (u2_u),
    .back      (u2_f),
    .eye       (u2_eye),
    .out_valid (result_valid),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v  <= 1'b0;
      x1_v <= 1'b0;
      x2_v <= 1'b0;
      u1_v <= 1'b0;
      u2_v <= 1'b0;
    end else if (adv) begin
      d_v  <= us_v;
      x1_v <= f_v;
      x2_v <= x1_v;
      u1_v <= s_v;
      u2_v <= u1_v;
    end
  end

`ifndef SYNTH
  a_side_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (result.side_x <= lav_pkg::UNIT_ONE) && (result.side_x >= -lav_pkg::UNIT_ONE) &&
      (result.side_y <= lav_pkg::UNIT_ONE) && (result.side_y >= -lav_pkg::UNIT_ONE) &&
      (result.side_z <= lav_pkg::UNIT_ONE) && (result.side_z >= -lav_pkg::UNIT_ONE))
    else $error("side row outside unit range");

  a_back_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (result.back_x <= lav_pkg::UNIT_ONE) && (result.back_x >= -lav_pkg::UNIT_ONE) &&
      (result.back_y <= lav_pkg::UNIT_ONE) && (result.back_y >= -lav_pkg::UNIT_ONE) &&
      (result.back_z <= lav_pkg::UNIT_ONE) && (result.back_z >= -lav_pkg::UNIT_ONE))
    else $error("back row outside unit range");

  a_upper_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (result.upper_x <= lav_pkg::UNIT_ONE) && (result.upper_x >= -lav_pkg::UNIT_ONE) &&
      (result.upper_y <= lav_pkg::UNIT_ONE) && (result.upper_y >= -lav_pkg::UNIT_ONE) &&
      (result.upper_z <= lav_pkg::UNIT_ONE) && (result.upper_z >= -lav_pkg::UNIT_ONE))
    else $error("upper row outside unit range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result transfer offered straight after reset");
`endif

endmodule
`default_nettype wire

/* hw/rtl/lav_scale.sv */
`default_nettype none
// lav_scale: three-stage block scaling of a signed 3-vector; magnitudes below 2^31,
// the largest in [2^30, 2^31) unless all are zero. Depends on lav_pkg.
module lav_scale #(
  parameter int IN_W   = 33,
  parameter int SIDE_W = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           in_valid,
  input  logic [2:0][IN_W-1:0]           vec,
  input  logic [SIDE_W-1:0]              in_side,
  output logic                           out_valid,
  output logic [2:0][lav_pkg::MAG_W-1:0] mag,
  output logic [2:0]                     neg,
  output logic [SIDE_W-1:0]              out_side
);
  localparam int MAG_W  = lav_pkg::MAG_W;
  localparam int LEN_W  = $clog2(IN_W + 1);
  localparam int WIDE_W = IN_W + MAG_W;

  logic [2:0][IN_W-1:0]   abs_c;
  logic [IN_W-1:0]        max_c;
  logic                   v1;
  logic [2:0][IN_W-1:0]   mag1;
  logic [IN_W-1:0]        max1;
  logic [2:0]             neg1;
  logic [SIDE_W-1:0]      side1;
  logic [LEN_W-1:0]       len_c;
  logic                   v2;
  logic [2:0][IN_W-1:0]   mag2;
  logic [LEN_W-1:0]       len2;
  logic [2:0]             neg2;
  logic [SIDE_W-1:0]      side2;
  logic [2:0][WIDE_W-1:0] wide_c;
  logic [2:0][MAG_W-1:0]  mag_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_c[i] = vec[i][IN_W-1] ? (~vec[i] + 1'b1) : vec[i];
    end
    max_c = abs_c[0];
    if (abs_c[1] > max_c) max_c = abs_c[1];
    if (abs_c[2] > max_c) max_c = abs_c[2];
  end

  always_comb begin
    len_c = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (max1[b]) len_c = LEN_W'(b + 1);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide_c[i] = {mag2[i], {MAG_W{1'b0}}} >> len2;
      mag_c[i]  = wide_c[i][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag1     <= abs_c;
      max1     <= max_c;
      neg1     <= {vec[2][IN_W-1], vec[1][IN_W-1], vec[0][IN_W-1]};
      side1    <= in_side;
      mag2     <= mag1;
      len2     <= len_c;
      neg2     <= neg1;
      side2    <= side1;
      mag      <= mag_c;
      neg      <= neg2;
      out_side <= side2;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/lav_norm.sv */
`default_nettype none
// lav_norm: pipelined normalisation of a signed 3-vector to Q2.30 unit length.
// Depends on lav_pkg and lav_scale.
module lav_norm #(
  parameter int IN_W   = 33,
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic                            in_valid,
  input  logic [2:0][IN_W-1:0]            vec,
  input  logic [SIDE_W-1:0]               in_side,
  output logic                            out_valid,
  output logic [2:0][lav_pkg::UNIT_W-1:0] unit,
  output logic [SIDE_W-1:0]               out_side
);
  localparam int MAG_W     = lav_pkg::MAG_W;
  localparam int UNIT_W    = lav_pkg::UNIT_W;
  localparam int FRAC_BITS = lav_pkg::FRAC_BITS;
  localparam int SQ_STEPS  = lav_pkg::SQ_STEPS;
  localparam int SQ_STAGES = lav_pkg::SQ_STAGES;
  localparam int DV_STEPS  = lav_pkg::DV_STEPS;
  localparam int DV_STAGES = lav_pkg::DV_STAGES;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int RAD_W     = 2 * SQ_STEPS * SQ_STAGES;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W;
  localparam int NUM_W     = MAG_W + FRAC_BITS + 1;

  typedef struct packed {
    logic [RAD_W-1:0]      rad;
    logic [RAD_W-1:0]      root;
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic [SIDE_W-1:0]     side;
  } sq_t;

  typedef struct packed {
    logic [2:0][REM_W-1:0] rem;
    logic [2:0][MAG_W-1:0] quo;
    logic [2:0][MAG_W-1:0] low;
    logic [ROOT_W-1:0]     len;
    logic [2:0]            neg;
    logic [SIDE_W-1:0]     side;
  } dv_t;

  function automatic logic [RAD_W-1:0] sq_bit(input int j);
    return RAD_W'(1) << (RAD_W - 2 - 2 * j);
  endfunction

  logic                   sc_v;
  logic [2:0][MAG_W-1:0]  sc_mag;
  logic [2:0]             sc_neg;
  logic [SIDE_W-1:0]      sc_side;
  logic                   q_v;
  logic [2:0][SQ_W-1:0]   q_sqr;
  logic [2:0][MAG_W-1:0]  q_mag;
  logic [2:0]             q_neg;
  logic [SIDE_W-1:0]      q_side;
  sq_t                    sq_r [SQ_STAGES+1];
  logic [SQ_STAGES:0]     sq_v;
  dv_t                    dv_c;
  logic [2:0][NUM_W-1:0]  num_c;
  dv_t                    dv_r [DV_STAGES+1];
  logic [DV_STAGES:0]     dv_v;
  logic [2:0][UNIT_W-1:0] unit_c;

  lav_scale #(
    .IN_W   (IN_W),
    .SIDE_W (SIDE_W)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .vec       (vec),
    .in_side   (in_side),
    .out_valid (sc_v),
    .mag       (sc_mag),
    .neg       (sc_neg),
    .out_side  (sc_side)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        q_sqr[i] <= SQ_W'(sc_mag[i]) * SQ_W'(sc_mag[i]);
      end
      q_mag         <= sc_mag;
      q_neg         <= sc_neg;
      q_side        <= sc_side;
      sq_r[0].rad   <= RAD_W'(q_sqr[0]) + RAD_W'(q_sqr[1]) + RAD_W'(q_sqr[2]);
      sq_r[0].root  <= '0;
      sq_r[0].mag   <= q_mag;
      sq_r[0].neg   <= q_neg;
      sq_r[0].side  <= q_side;
    end
  end

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
    sq_t nxt;
    always_comb begin
      nxt = sq_r[k];
      for (int t = 0; t < SQ_STEPS; t++) begin
        if (nxt.rad >= nxt.root + sq_bit(k * SQ_STEPS + t)) begin
          nxt.rad  = nxt.rad - (nxt.root + sq_bit(k * SQ_STEPS + t));
          nxt.root = (nxt.root >> 1) + sq_bit(k * SQ_STEPS + t);
        end else begin
          nxt.root = nxt.root >> 1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) sq_r[k+1] <= nxt;
    end
  end

  always_comb begin
    dv_c      = '0;
    dv_c.len  = sq_r[SQ_STAGES].root[ROOT_W-1:0];
    dv_c.neg  = sq_r[SQ_STAGES].neg;
    dv_c.side = sq_r[SQ_STAGES].side;
    for (int i = 0; i < 3; i++) begin
      num_c[i]       = NUM_W'({sq_r[SQ_STAGES].mag[i], {FRAC_BITS{1'b0}}})
                     + NUM_W'(dv_c.len >> 1);
      dv_c.rem[i]    = REM_W'(num_c[i][NUM_W-1:MAG_W]);
      dv_c.low[i]    = num_c[i][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) dv_r[0] <= dv_c;
  end

  for (genvar k = 0; k < DV_STAGES; k++) begin : g_dv
    dv_t nxt;
    always_comb begin
      nxt = dv_r[k];
      for (int t = 0; t < DV_STEPS; t++) begin
        if (k * DV_STEPS + t < MAG_W) begin
          for (int i = 0; i < 3; i++) begin
            if ({nxt.rem[i], nxt.low[i][MAG_W-1]} >= {1'b0, nxt.len}) begin
              nxt.rem[i] = REM_W'({nxt.rem[i], nxt.low[i][MAG_W-1]} - {1'b0, nxt.len});
              nxt.quo[i] = {nxt.quo[i][MAG_W-2:0], 1'b1};
            end else begin
              nxt.rem[i] = {nxt.rem[i][REM_W-2:0], nxt.low[i][MAG_W-1]};
              nxt.quo[i] = {nxt.quo[i][MAG_W-2:0], 1'b0};
            end
            nxt.low[i] = nxt.low[i] << 1;
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) dv_r[k+1] <= nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_r[DV_STAGES].len == '0) begin
        unit_c[i] = '0;
      end else if (dv_r[DV_STAGES].neg[i]) begin
        unit_c[i] = -UNIT_W'(dv_r[DV_STAGES].quo[i]);
      end else begin
        unit_c[i] = UNIT_W'(dv_r[DV_STAGES].quo[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unit     <= unit_c;
      out_side <= dv_r[DV_STAGES].side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_v       <= 1'b0;
      sq_v      <= '0;
      dv_v      <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      q_v       <= sc_v;
      sq_v      <= {sq_v[SQ_STAGES-1:0], q_v};
      dv_v      <= {dv_v[DV_STAGES-1:0], sq_v[SQ_STAGES]};
      out_valid <= dv_v[DV_STAGES];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/lav_xlat.sv */
`default_nettype none
// lav_xlat: three-stage translation column (-row . eye, saturated) and result packing.
// Depends on lav_pkg.
module lav_xlat (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  lav_pkg::uvec_t side,
  input  lav_pkg::uvec_t upper,
  input  lav_pkg::uvec_t back,
  input  lav_pkg::cvec_t eye,
  output logic           out_valid,
  output lav_pkg::out_t  result
);
  localparam int COORD_W   = lav_pkg::COORD_W;
  localparam int UNIT_W    = lav_pkg::UNIT_W;
  localparam int FRAC_BITS = lav_pkg::FRAC_BITS;
  localparam int PW        = UNIT_W + COORD_W;
  localparam int SW        = PW + 2;
  localparam int TW        = SW - FRAC_BITS;
  localparam int XW        = TW + 1;

  lav_pkg::uvec_t        rows_c [3];
  logic signed [PW-1:0]  prod [3][3];
  logic                  v1;
  lav_pkg::uvec_t        side1, upper1, back1;
  logic signed [SW-1:0]  sum_c [3];
  logic signed [TW-1:0]  t_c [3];
  logic signed [TW-1:0]  t2 [3];
  logic                  v2;
  lav_pkg::uvec_t        side2, upper2, back2;
  logic signed [XW-1:0]  nr_c [3];
  logic [COORD_W-1:0]    sat_c [3];

  always_comb begin
    rows_c[0] = side;
    rows_c[1] = upper;
    rows_c[2] = back;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          prod[r][j] <= $signed(rows_c[r][j]) * $signed(eye[j]);
        end
      end
      side1  <= side;
      upper1 <= upper;
      back1  <= back;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_c[r] = SW'(prod[r][0]) + SW'(prod[r][1]) + SW'(prod[r][2])
               + (SW'(1) <<< (FRAC_BITS - 1));
      t_c[r]   = TW'(sum_c[r] >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2     <= t_c;
      side2  <= side1;
      upper2 <= upper1;
      back2  <= back1;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nr_c[r] = -XW'(t2[r]);
      if ((nr_c[r][XW-1:COORD_W-1] == '0) || (nr_c[r][XW-1:COORD_W-1] == '1)) begin
        sat_c[r] = nr_c[r][COORD_W-1:0];
      end else if (nr_c[r][XW-1]) begin
        sat_c[r] = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        sat_c[r] = {1'b0, {(COORD_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.side_x  <= side2[0];
      result.side_y  <= side2[1];
      result.side_z  <= side2[2];
      result.upper_x <= upper2[0];
      result.upper_y <= upper2[1];
      result.upper_z <= upper2[2];
      result.back_x  <= back2[0];
      result.back_y  <= back2[1];
      result.back_z  <= back2[2];
      result.shift_x <= sat_c[0];
      result.shift_y <= sat_c[1];
      result.shift_z <= sat_c[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule
`default_nettype wire
